### rtl/task_shard_lifecycle_fsm_defines.svh
// -----------------------------------------------------------------------------
// Task shard lifecycle FSM assertion macros
// Shared concurrent assertion forms used by the lifecycle RTL.
// -----------------------------------------------------------------------------
`ifndef TASK_SHARD_LIFECYCLE_FSM_DEFINES_SVH
`define TASK_SHARD_LIFECYCLE_FSM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSLF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lifecycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lifecycle assertion failed");

`endif

### rtl/tslf_pkg.sv
// -----------------------------------------------------------------------------
// Task shard lifecycle package
// Event codes, state codes and request/response types of the shard FSM.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tslf_pkg;

    // Event codes carried by a request.
    typedef enum logic [2:0] {
        OP_READY          = 3'd0,
        OP_BEGIN_ACT      = 3'd1,
        OP_COMPLETE_ACT   = 3'd2,
        OP_CANCEL         = 3'd3,
        OP_FAIL           = 3'd4,
        OP_BEGIN_FLUSH    = 3'd5,
        OP_FINISH_FLUSH   = 3'd6
    } t_op;

    // Outcome codes of an activation completion.
    typedef enum logic [3:0] {
        OC_IDLE         = 4'd0,
        OC_BLK_INPUT    = 4'd1,
        OC_BLK_DEP      = 4'd2,
        OC_BLK_OUTPUT   = 4'd3,
        OC_BLK_RESOURCE = 4'd4,
        OC_FLUSHING     = 4'd5,
        OC_DONE         = 4'd6,
        OC_FAILED       = 4'd7,
        OC_RESCHEDULE   = 4'd8
    } t_outcome;

    // Lifecycle states of a shard.
    typedef enum logic [3:0] {
        ST_DORMANT      = 4'd0,
        ST_IDLE         = 4'd1,
        ST_SCHEDULED    = 4'd2,
        ST_RUNNING      = 4'd3,
        ST_BLK_INPUT    = 4'd4,
        ST_BLK_DEP      = 4'd5,
        ST_BLK_OUTPUT   = 4'd6,
        ST_BLK_RESOURCE = 4'd7,
        ST_FLUSHING     = 4'd8,
        ST_CANCELLING   = 4'd9,
        ST_DONE         = 4'd10,
        ST_FAILED       = 4'd11
    } t_shard_state;

    // One event request.
    typedef struct packed {
        t_op      operation;
        t_outcome outcome;
        logic     flush_success;
    } t_req;

    // One event response.
    typedef struct packed {
        logic         accepted;
        logic         scheduled_now;
        t_shard_state shard_state;
        logic         cancel_requested;
        logic         failure_requested;
    } t_resp;

    // Stored context of the shard.
    typedef struct packed {
        t_shard_state state;
        logic         cancel;
        logic         fail;
        logic         ready_pending;
    } t_ctx;

endpackage

### rtl/tslf_transition.sv
// -----------------------------------------------------------------------------
// Task shard lifecycle transition logic
// Computes the next shard context and the response for one event request.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tslf_transition (
    input  tslf_pkg::t_ctx  i_ctx,
    input  tslf_pkg::t_req  i_req,
    output tslf_pkg::t_ctx  o_ctx,
    output tslf_pkg::t_resp o_resp
);
    import tslf_pkg::*;

    t_ctx         ctx;
    logic         accepted;
    logic         scheduled;
    logic         settled;
    logic         terminal;
    logic         resched;
    t_shard_state landing;

    // States in which a ready notice is ignored.
    assign settled = (i_ctx.state == ST_FLUSHING) || (i_ctx.state == ST_CANCELLING) ||
                     (i_ctx.state == ST_DONE) || (i_ctx.state == ST_FAILED);

    // Decode the completion outcome into a landing state.
    always_comb begin
        landing  = ST_FAILED;
        terminal = 1'b1;
        resched  = 1'b0;
        case (i_req.outcome)
            OC_IDLE: begin
                landing  = ST_IDLE;
                terminal = 1'b0;
            end
            OC_BLK_INPUT: begin
                landing  = ST_BLK_INPUT;
                terminal = 1'b0;
            end
            OC_BLK_DEP: begin
                landing  = ST_BLK_DEP;
                terminal = 1'b0;
            end
            OC_BLK_OUTPUT: begin
                landing  = ST_BLK_OUTPUT;
                terminal = 1'b0;
            end
            OC_BLK_RESOURCE: begin
                landing  = ST_BLK_RESOURCE;
                terminal = 1'b0;
            end
            OC_FLUSHING:   landing = ST_FLUSHING;
            OC_DONE:       landing = ST_DONE;
            OC_RESCHEDULE: resched = 1'b1;
            // Failed and all meaningless codes end in failure.
            default:       landing = ST_FAILED;
        endcase
    end

    // Event decode and state transition.
    always_comb begin
        ctx       = i_ctx;
        accepted  = 1'b1;
        scheduled = 1'b0;
        unique case (i_req.operation)
            OP_READY: begin
                if ((i_ctx.state == ST_SCHEDULED) || (i_ctx.state == ST_RUNNING)) begin
                    ctx.ready_pending = 1'b1;
                end else if (!settled) begin
                    ctx.state = ST_SCHEDULED;
                    scheduled = 1'b1;
                end
            end
            OP_BEGIN_ACT: begin
                if (i_ctx.state == ST_SCHEDULED) begin
                    ctx.state = ST_RUNNING;
                end else begin
                    accepted = 1'b0;
                end
            end
            OP_COMPLETE_ACT: begin
                if (i_ctx.state != ST_RUNNING) begin
                    accepted = 1'b0;
                end else if (i_ctx.fail) begin
                    ctx.state         = ST_FAILED;
                    ctx.ready_pending = 1'b0;
                end else if (i_ctx.cancel) begin
                    ctx.state         = ST_CANCELLING;
                    ctx.ready_pending = 1'b0;
                end else if (resched) begin
                    // Reschedule passes through idle straight into scheduled.
                    ctx.state = ST_SCHEDULED;
                    scheduled = 1'b1;
                end else if (terminal) begin
                    ctx.state         = landing;
                    ctx.ready_pending = 1'b0;
                end else if (i_ctx.ready_pending) begin
                    // A ready notice seen while busy schedules the shard now.
                    ctx.state         = ST_SCHEDULED;
                    ctx.ready_pending = 1'b0;
                    scheduled         = 1'b1;
                end else begin
                    ctx.state = landing;
                end
            end
            OP_CANCEL: begin
                ctx.cancel = 1'b1;
                if ((i_ctx.state != ST_RUNNING) && (i_ctx.state != ST_DONE) &&
                    (i_ctx.state != ST_FAILED)) begin
                    ctx.state         = ST_CANCELLING;
                    ctx.ready_pending = 1'b0;
                end
            end
            OP_FAIL: begin
                ctx.fail = 1'b1;
                if ((i_ctx.state != ST_RUNNING) && (i_ctx.state != ST_DONE)) begin
                    ctx.state         = ST_FAILED;
                    ctx.ready_pending = 1'b0;
                end
            end
            OP_BEGIN_FLUSH: begin
                if ((i_ctx.state == ST_DONE) || (i_ctx.state == ST_FAILED) ||
                    (i_ctx.state == ST_CANCELLING) || (i_ctx.state == ST_RUNNING) ||
                    (i_ctx.state == ST_SCHEDULED)) begin
                    accepted = 1'b0;
                end else begin
                    ctx.state         = ST_FLUSHING;
                    ctx.ready_pending = 1'b0;
                end
            end
            OP_FINISH_FLUSH: begin
                if (i_ctx.state == ST_FLUSHING) begin
                    ctx.state = i_req.flush_success ? ST_DONE : ST_FAILED;
                end else begin
                    accepted = 1'b0;
                end
            end
            // The unused event code is rejected without any change.
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    assign o_ctx = ctx;

    // Response reflects the context after the event.
    assign o_resp.accepted          = accepted;
    assign o_resp.scheduled_now     = scheduled;
    assign o_resp.shard_state       = ctx.state;
    assign o_resp.cancel_requested  = ctx.cancel;
    assign o_resp.failure_requested = ctx.fail;

endmodule

### rtl/task_shard_lifecycle_fsm.sv
// Lifecycle state machine of one work shard. Each accepted request is one event, and each
// event produces exactly one response with the accept bit, the scheduled-now bit, the
// resulting state and both sticky request flags. The block takes one request per clock
// while the response side keeps up. The request is captured in an input register at the
// accepting edge. When the response register is free or being drained, the transition
// logic updates the stored shard context and fills the response register. A response side
// that holds off delays both this update and the next request. The rate is set by the
// single stored context, which is read and written once per event. The shard starts
// dormant with all flags clear after reset.
// -----------------------------------------------------------------------------
// Task shard lifecycle FSM top level
// Input register, stored shard context and response register around the
// transition logic.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "task_shard_lifecycle_fsm_defines.svh"

module task_shard_lifecycle_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  tslf_pkg::t_req  i_req,
    output logic            o_resp_valid,
    input  logic            i_resp_ready,
    output tslf_pkg::t_resp o_resp
);
    import tslf_pkg::*;

    logic  r_in_valid;
    t_req  r_in_req;
    logic  r_out_valid;
    t_resp r_out_resp;
    t_ctx  r_ctx;
    t_ctx  n_ctx;
    t_resp n_resp;
    logic  advance;

    // A held request moves on when the response register is free or being drained.
    assign advance     = r_in_valid && (!r_out_valid || i_resp_ready);
    assign o_req_ready = !r_in_valid || advance;

    tslf_transition u_transition (
        .i_ctx  (r_ctx),
        .i_req  (r_in_req),
        .o_ctx  (n_ctx),
        .o_resp (n_resp)
    );

    // Input request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
        if (o_req_ready && i_req_valid) begin
            r_in_req <= i_req;
        end
    end

    // Shard context, updated once per event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state         <= ST_DORMANT;
            r_ctx.cancel        <= 1'b0;
            r_ctx.fail          <= 1'b0;
            r_ctx.ready_pending <= 1'b0;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_resp_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_resp <= n_resp;
        end
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out_resp;

    // A rejected event never schedules the shard.
    `TSLF_ASSERT_NOW(a_reject_no_sched, i_clk, i_rst_n, r_out_valid && !r_out_resp.accepted, !r_out_resp.scheduled_now)
    // Scheduling always lands in the scheduled state.
    `TSLF_ASSERT_NOW(a_sched_state, i_clk, i_rst_n, r_out_valid && r_out_resp.scheduled_now, r_out_resp.shard_state == ST_SCHEDULED)
    // The cancel request flag is sticky.
    `TSLF_ASSERT_NEXT(a_cancel_sticky, i_clk, i_rst_n, r_ctx.cancel, r_ctx.cancel)
    // The failure request flag is sticky.
    `TSLF_ASSERT_NEXT(a_fail_sticky, i_clk, i_rst_n, r_ctx.fail, r_ctx.fail)
    // A pending ready notice exists only while the shard is scheduled or running.
    `TSLF_ASSERT_NOW(a_pending_busy, i_clk, i_rst_n, r_ctx.ready_pending, (r_ctx.state == ST_SCHEDULED) || (r_ctx.state == ST_RUNNING))

endmodule

### tb/shard_lifecycle_checker.sv
// -----------------------------------------------------------------------------
// Shard lifecycle response checker
// Watches the request and response channels of the lifecycle FSM. It keeps
// its own copy of the shard state and flags, works out the response to each
// accepted request, and compares every accepted response with the oldest one
// still waiting.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shard_lifecycle_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  tslf_pkg::t_req  i_req,
    input  logic            i_resp_valid,
    input  logic            i_resp_ready,
    input  tslf_pkg::t_resp i_resp,
    output int              o_mismatches,
    output int              o_in_flight
);

    import tslf_pkg::*;

    // Predicted shard context.
    t_shard_state shard_st;
    logic         cancel_seen;
    logic         fail_seen;
    logic         ready_held;

    // Responses owed by the block, oldest first.
    t_resp due_q[$];

    int n_bad       = 0;
    int n_seen      = 0;
    int n_in_flight = 0;

    assign o_mismatches = n_bad;
    assign o_in_flight  = n_in_flight;

    // Applies one event to the predicted context and returns the response.
    function automatic t_resp next_shard_response(input t_req ev);
        t_resp        r;
        t_shard_state cur;
        t_shard_state nxt;
        logic         ok;
        logic         sched;
        cur   = shard_st;
        ok    = 1'b1;
        sched = 1'b0;
        case (ev.operation)
            OP_READY: begin
                if (cur inside {ST_FLUSHING, ST_CANCELLING, ST_DONE, ST_FAILED}) begin
                    // Shard is past the point of being scheduled: notice dropped.
                end else if (cur inside {ST_SCHEDULED, ST_RUNNING}) begin
                    ready_held = 1'b1;
                end else begin
                    shard_st = ST_SCHEDULED;
                    sched    = 1'b1;
                end
            end
            OP_BEGIN_ACT: begin
                if (cur != ST_SCHEDULED)
                    ok = 1'b0;
                else
                    shard_st = ST_RUNNING;
            end
            OP_COMPLETE_ACT: begin
                if (cur != ST_RUNNING) begin
                    ok = 1'b0;
                end else if (fail_seen) begin
                    // A pending failure wins over a pending cancel and the outcome.
                    shard_st   = ST_FAILED;
                    ready_held = 1'b0;
                end else if (cancel_seen) begin
                    shard_st   = ST_CANCELLING;
                    ready_held = 1'b0;
                end else if (ev.outcome == OC_RESCHEDULE) begin
                    // Goes through idle straight back to scheduled; the held
                    // ready notice is kept.
                    shard_st = ST_SCHEDULED;
                    sched    = 1'b1;
                end else begin
                    case (ev.outcome)
                        OC_IDLE:         nxt = ST_IDLE;
                        OC_BLK_INPUT:    nxt = ST_BLK_INPUT;
                        OC_BLK_DEP:      nxt = ST_BLK_DEP;
                        OC_BLK_OUTPUT:   nxt = ST_BLK_OUTPUT;
                        OC_BLK_RESOURCE: nxt = ST_BLK_RESOURCE;
                        OC_FLUSHING:     nxt = ST_FLUSHING;
                        OC_DONE:         nxt = ST_DONE;
                        default:         nxt = ST_FAILED;
                    endcase
                    if (nxt inside {ST_DONE, ST_FAILED, ST_FLUSHING}) begin
                        shard_st   = nxt;
                        ready_held = 1'b0;
                    end else if (ready_held) begin
                        // A ready notice seen while busy schedules the shard now.
                        shard_st   = ST_SCHEDULED;
                        ready_held = 1'b0;
                        sched      = 1'b1;
                    end else begin
                        shard_st = nxt;
                    end
                end
            end
            OP_CANCEL: begin
                cancel_seen = 1'b1;
                if (!(cur inside {ST_RUNNING, ST_DONE, ST_FAILED})) begin
                    shard_st   = ST_CANCELLING;
                    ready_held = 1'b0;
                end
            end
            OP_FAIL: begin
                fail_seen = 1'b1;
                if (!(cur inside {ST_RUNNING, ST_DONE})) begin
                    shard_st   = ST_FAILED;
                    ready_held = 1'b0;
                end
            end
            OP_BEGIN_FLUSH: begin
                if (cur inside {ST_DONE, ST_FAILED, ST_CANCELLING, ST_RUNNING, ST_SCHEDULED}) begin
                    ok = 1'b0;
                end else begin
                    shard_st   = ST_FLUSHING;
                    ready_held = 1'b0;
                end
            end
            OP_FINISH_FLUSH: begin
                if (cur != ST_FLUSHING)
                    ok = 1'b0;
                else
                    shard_st = ev.flush_success ? ST_DONE : ST_FAILED;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        r.accepted          = ok;
        r.scheduled_now     = sched;
        r.shard_state       = shard_st;
        r.cancel_requested  = cancel_seen;
        r.failure_requested = fail_seen;
        return r;
    endfunction

    // Counts a field that differs and reports the first few.
    task automatic check_field(input string what, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
                $display("[%0t] response %0d: %s expected %0d, got %0d",
                         $time, n_seen, what, want, got);
        end
    endtask

    // Track requests and responses at each clock edge.
    always @(posedge i_clk) begin : track
        t_resp want;
        if (!i_rst_n) begin
            shard_st    = ST_DORMANT;
            cancel_seen = 1'b0;
            fail_seen   = 1'b0;
            ready_held  = 1'b0;
            due_q.delete();
            n_in_flight <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                due_q.push_back(next_shard_response(i_req));
            if (i_resp_valid && i_resp_ready) begin
                n_seen++;
                if (due_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] response %0d arrived with no request outstanding",
                                 $time, n_seen);
                end else begin
                    want = due_q.pop_front();
                    check_field("accepted", want.accepted, i_resp.accepted);
                    check_field("scheduled_now", want.scheduled_now, i_resp.scheduled_now);
                    check_field("shard_state", want.shard_state, i_resp.shard_state);
                    check_field("cancel_requested", want.cancel_requested,
                                i_resp.cancel_requested);
                    check_field("failure_requested", want.failure_requested,
                                i_resp.failure_requested);
                end
            end
            n_in_flight <= n_in_flight + int'(i_req_valid && i_req_ready)
                                       - int'(i_resp_valid && i_resp_ready);
        end
    end

endmodule

### tb/task_shard_lifecycle_fsm_test.sv
// -----------------------------------------------------------------------------
// Task shard lifecycle FSM regression
// Drives lifecycle events into the shard FSM: a directed walk through the
// non-terminal states, a long random run of scheduling traffic, and a closing
// sequence that takes the shard into one of its terminal states. The
// response side stalls at random and twice for a long stretch; the checker
// beside the block predicts and compares every response.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_shard_lifecycle_fsm_test;

    import tslf_pkg::*;

    localparam int  MID_ITEMS      = 1500;
    localparam int  TAIL_ITEMS     = 60;
    localparam int  RX_HOLD_CYCLES = 64;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  SETTLE_CYCLES  = 10;
    localparam t_op OP_UNUSED      = t_op'(3'd7);

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    t_req  req;
    logic  resp_valid;
    logic  resp_ready;
    t_resp resp;

    int n_mismatch;
    int in_flight;
    int tx_idle_pct = 18;
    int rx_idle_pct = 48;
    int hold_asks   = 0;

    task_shard_lifecycle_fsm DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .o_req_ready  (req_ready),
        .i_req        (req),
        .o_resp_valid (resp_valid),
        .i_resp_ready (resp_ready),
        .o_resp       (resp)
    );

    shard_lifecycle_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_resp_valid (resp_valid),
        .i_resp_ready (resp_ready),
        .i_resp       (resp),
        .o_mismatches (n_mismatch),
        .o_in_flight  (in_flight)
    );

    // 250 MHz clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offers one request, with a random gap in front, and waits until taken.
    task automatic send_req(input t_op op, input t_outcome oc, input logic fs);
        t_req item;
        item.operation     = op;
        item.outcome       = oc;
        item.flush_success = fs;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every response is back.
    task automatic wait_all_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    // Response side: random stalls, plus a long hold-off when asked.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        resp_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                resp_ready <= 1'b0;
                hold_left--;
            end else begin
                resp_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (resp_valid && resp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("task_shard_lifecycle_fsm regression: fail");
        $finish;
    end

    // Stimulus.
    initial begin
        int       k;
        t_op      op;
        t_outcome oc;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk from dormant through scheduling, running and blocking.
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_DONE,          1'b1);
        send_req(OP_FINISH_FLUSH, OC_IDLE,          1'b1);
        send_req(OP_UNUSED,       t_outcome'(4'hf), 1'b1);
        send_req(OP_READY,        OC_IDLE,          1'b0);
        send_req(OP_READY,        OC_IDLE,          1'b0);
        send_req(OP_BEGIN_FLUSH,  OC_IDLE,          1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_BEGIN_FLUSH,  OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_IDLE,          1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_BLK_INPUT,     1'b0);
        send_req(OP_READY,        OC_IDLE,          1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_READY,        OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_RESCHEDULE,    1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_BLK_RESOURCE,  1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_BLK_DEP,       1'b0);
        send_req(OP_READY,        OC_IDLE,          1'b0);
        send_req(OP_BEGIN_ACT,    OC_IDLE,          1'b0);
        send_req(OP_COMPLETE_ACT, OC_BLK_OUTPUT,    1'b0);

        // Random scheduling traffic that keeps the shard out of its terminal
        // states, in three idling regimes.
        for (int i = 0; i < MID_ITEMS; i++) begin
            if (i == MID_ITEMS / 3) begin
                wait_all_responses();
                tx_idle_pct = 48;
                rx_idle_pct = 18;
            end else if (i == 2 * MID_ITEMS / 3) begin
                wait_all_responses();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == MID_ITEMS / 6 || i == 5 * MID_ITEMS / 6)
                hold_asks <= hold_asks + 1;
            oc = t_outcome'(4'($urandom_range(15)));
            k  = $urandom_range(99);
            if (k < 34) begin
                op = OP_READY;
            end else if (k < 58) begin
                op = OP_BEGIN_ACT;
            end else if (k < 88) begin
                op = OP_COMPLETE_ACT;
                k  = $urandom_range(5);
                oc = (k == 5) ? OC_RESCHEDULE : t_outcome'(4'(k));
            end else if (k < 94) begin
                op = OP_FINISH_FLUSH;
            end else begin
                op = OP_UNUSED;
            end
            send_req(op, oc, 1'($urandom_range(1)));
        end
        wait_all_responses();

        // Bring the shard to running: ready then begin works from any
        // non-terminal state.
        send_req(OP_READY,     OC_IDLE, 1'b0);
        send_req(OP_BEGIN_ACT, OC_IDLE, 1'b0);

        // Closing sequence: one route into a terminal state per run.
        case ($urandom_range(5))
            0: begin
                // Cancel while running takes effect at completion.
                send_req(OP_CANCEL,       OC_IDLE, 1'b0);
                send_req(OP_COMPLETE_ACT, t_outcome'(4'($urandom_range(15))), 1'b0);
                send_req(OP_READY,        OC_IDLE, 1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE, 1'b0);
                send_req(OP_FAIL,         OC_IDLE, 1'b0);
                send_req(OP_READY,        OC_IDLE, 1'b0);
            end
            1: begin
                // Failure while running takes effect at completion.
                send_req(OP_FAIL,         OC_IDLE, 1'b0);
                send_req(OP_CANCEL,       OC_IDLE, 1'b0);
                send_req(OP_COMPLETE_ACT, t_outcome'(4'($urandom_range(15))), 1'b0);
                send_req(OP_READY,        OC_IDLE, 1'b0);
                send_req(OP_COMPLETE_ACT, OC_IDLE, 1'b0);
            end
            2: begin
                // Flush requested by the activation, then finished.
                send_req(OP_COMPLETE_ACT, OC_FLUSHING, 1'b0);
                send_req(OP_READY,        OC_IDLE,     1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE,     1'b0);
                send_req(OP_FINISH_FLUSH, OC_IDLE,     1'($urandom_range(1)));
                send_req(OP_READY,        OC_IDLE,     1'b0);
                send_req(OP_CANCEL,       OC_IDLE,     1'b0);
                send_req(OP_FAIL,         OC_IDLE,     1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE,     1'b0);
            end
            3: begin
                // Activation ends done or failed, out-of-range codes included.
                k = $urandom_range(6, 14);
                send_req(OP_COMPLETE_ACT, t_outcome'(4'((k == 8) ? 15 : k)), 1'b0);
                send_req(OP_READY,        OC_IDLE, 1'b0);
                send_req(OP_FAIL,         OC_IDLE, 1'b0);
                send_req(OP_CANCEL,       OC_IDLE, 1'b0);
                send_req(OP_FINISH_FLUSH, OC_IDLE, 1'b1);
            end
            4: begin
                // Cancel outside running goes straight to cancelling.
                send_req(OP_COMPLETE_ACT, OC_IDLE, 1'b0);
                send_req(OP_CANCEL,       OC_IDLE, 1'b0);
                send_req(OP_READY,        OC_IDLE, 1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE, 1'b0);
                send_req(OP_FAIL,         OC_IDLE, 1'b0);
            end
            default: begin
                // Flush from a dependency block ends in failure; a held schedule rejects it.
                send_req(OP_COMPLETE_ACT, OC_BLK_DEP, 1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE,    1'b0);
                send_req(OP_BEGIN_FLUSH,  OC_IDLE,    1'b0);
                send_req(OP_FINISH_FLUSH, OC_IDLE,    1'b0);
                send_req(OP_READY,        OC_IDLE,    1'b0);
            end
        endcase

        // Unrestricted noise on whatever state the shard ended in.
        for (int i = 0; i < TAIL_ITEMS; i++)
            send_req(t_op'(3'($urandom_range(7))), t_outcome'(4'($urandom_range(15))),
                     1'($urandom_range(1)));

        // Drain, let any stray response show up, then give the verdict.
        wait_all_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_mismatch == 0 && in_flight == 0)
            $display("task_shard_lifecycle_fsm regression: pass");
        else
            $display("task_shard_lifecycle_fsm regression: fail");
        $finish;
    end

endmodule
